// ----- rtl/sfa_pkg.sv -----
// Shared types, constants and helpers for the sparse four-row int8 accumulator.
// Used by the lane and top-level modules; depends on nothing else.
package sfa_pkg;

   localparam int LANES           = 16;
   localparam int LANE_W          = 4;
   localparam int TILE_ROWS       = 4;
   localparam int PATTERN_COUNT   = 15;
   localparam int DEF_MAX_COLS    = 64;
   localparam int DEF_KERNEL_ROWS = 256;
   localparam int CFG_W           = 7;

   typedef enum logic [1:0] {
      OP_LOAD = 2'd0,
      OP_ACC  = 2'd1,
      OP_READ = 2'd2,
      OP_NONE = 2'd3
   } op_type;

   // Issue-stage command common to all lanes.
   typedef struct packed {
      logic rd;
      logic kwe;
   } issue_type;

   // Write-back stage command common to all lanes.
   typedef struct packed {
      logic [TILE_ROWS-1:0] acc_en;
      logic [TILE_ROWS-1:0] valid;
      logic [TILE_ROWS-1:0] clr_en;
   } wb_type;

   // Tile rows selected by each pattern, bit r for row r.
   function automatic logic [TILE_ROWS-1:0] row_mask(input logic [3:0] pattern);
      logic [TILE_ROWS-1:0] m;
      case (pattern)
         4'd0:    m = 4'hF;
         4'd1:    m = 4'h7;
         4'd2:    m = 4'hB;
         4'd3:    m = 4'hD;
         4'd4:    m = 4'hE;
         4'd5:    m = 4'h3;
         4'd6:    m = 4'h5;
         4'd7:    m = 4'h9;
         4'd8:    m = 4'h6;
         4'd9:    m = 4'hA;
         4'd10:   m = 4'hC;
         4'd11:   m = 4'h1;
         4'd12:   m = 4'h2;
         4'd13:   m = 4'h4;
         4'd14:   m = 4'h8;
         default: m = 4'h0;
      endcase
      return m;
   endfunction

   // Hands the i-th value to the i-th selected row, in ascending row order.
   function automatic logic [TILE_ROWS-1:0][7:0] spread_values(
      input logic [TILE_ROWS-1:0]      mask,
      input logic [TILE_ROWS-1:0][7:0] vals
   );
      logic [TILE_ROWS-1:0][7:0] res;
      logic [1:0]                nxt;
      res = '0;
      nxt = '0;
      for (int r = 0; r < TILE_ROWS; r++) begin
         if (mask[r]) begin
            res[r] = vals[nxt];
            nxt    = nxt + 2'd1;
         end
      end
      return res;
   endfunction

endpackage

// ----- rtl/sfa_req_if.sv -----
// Request channel of the sparse four-row int8 accumulator: valid/ready and one word.
// No dependencies.
interface sfa_req_if;
   logic              valid;
   logic              ready;
   logic [1:0]        opcode;
   logic [7:0]        kernel_row;
   logic [5:0]        column;
   logic [1:0]        tile_row;
   logic signed [7:0] load_byte;
   logic [3:0]        pattern;
   logic signed [7:0] val_first;
   logic signed [7:0] val_second;
   logic signed [7:0] val_third;
   logic signed [7:0] val_fourth;

   modport source (
      output valid, opcode, kernel_row, column, tile_row, load_byte, pattern,
             val_first, val_second, val_third, val_fourth,
      input  ready
   );
   modport sink (
      input  valid, opcode, kernel_row, column, tile_row, load_byte, pattern,
             val_first, val_second, val_third, val_fourth,
      output ready
   );
endinterface

// ----- rtl/sfa_rsp_if.sv -----
// Response channel of the sparse four-row int8 accumulator: valid/ready and one word.
// No dependencies.
interface sfa_rsp_if;
   logic              valid;
   logic              ready;
   logic signed [7:0] read_value;

   modport source (output valid, read_value, input ready);
   modport sink (input valid, read_value, output ready);
endinterface

// ----- rtl/sfa_lane.sv -----
// One column lane: kernel memory slice, four tile-row memory slices and the MAC.
// Depends on sfa_pkg.
module sfa_lane import sfa_pkg::*; #(
   parameter int  MAX_COLS    = DEF_MAX_COLS,
   parameter int  KERNEL_ROWS = DEF_KERNEL_ROWS,
   localparam int CHUNKS      = (MAX_COLS + LANES - 1) / LANES,
   localparam int CHUNK_W     = (CHUNKS > 1) ? $clog2(CHUNKS) : 1,
   localparam int KDEPTH      = KERNEL_ROWS * CHUNKS,
   localparam int KADDR_W     = (KDEPTH > 1) ? $clog2(KDEPTH) : 1
) (
   input  logic                      clock,
   input  issue_type                 issue,
   input  logic [KADDR_W-1:0]        kaddr,
   input  logic [CHUNK_W-1:0]        chunk,
   input  logic [7:0]                kdata,
   input  wb_type                    wb,
   input  logic [CHUNK_W-1:0]        wb_chunk,
   input  logic [TILE_ROWS-1:0][7:0] row_val,
   input  logic                      lane_sel,
   input  logic                      lane_on,
   output logic [TILE_ROWS-1:0][7:0] tile_q
);

   logic [7:0] kmem [KDEPTH];
   logic [7:0] tmem [TILE_ROWS][CHUNKS];

   logic [7:0]                kq_ff;
   logic [TILE_ROWS-1:0][7:0] tq_ff;
   logic [TILE_ROWS-1:0][7:0] sum;

   always_ff @(posedge clock) begin
      if (issue.kwe && lane_sel) begin
         kmem[kaddr] <= kdata;
      end
      if (issue.rd) begin
         kq_ff <= kmem[kaddr];
      end
   end

   // Entries of a tile word that was never accumulated read as zero.
   always_comb begin
      for (int r = 0; r < TILE_ROWS; r++) begin
         tile_q[r] = wb.valid[r] ? tq_ff[r] : 8'd0;
         sum[r]    = tile_q[r] + 8'(row_val[r] * kq_ff);
      end
   end

   for (genvar r = 0; r < TILE_ROWS; r++) begin : g_row
      always_ff @(posedge clock) begin
         if (issue.rd) begin
            tq_ff[r] <= tmem[r][chunk];
         end
         if (wb.acc_en[r]) begin
            tmem[r][wb_chunk] <= lane_on ? sum[r] : tile_q[r];
         end else if (wb.clr_en[r] && lane_sel) begin
            tmem[r][wb_chunk] <= 8'd0;
         end
      end
   end

endmodule

// ----- rtl/sparse_four_row_int8_accumulate.sv -----
// A load or read-and-clear word passes through the issue, drain and result states after
// acceptance; an accumulate word issues ceil(active_cols/16) column chunks to the 16 lanes,
// one per cycle, and an ignored word goes straight to the result state. A new word is taken
// only once the previous one has left the result state. Reset (synchronous, active high)
// zeroes the tile through per-word valid bits, sets active_cols to 64 and empties the
// response register; kernel bytes stay undefined until written.
module sparse_four_row_int8_accumulate import sfa_pkg::*; #(
   parameter int MAX_COLS    = DEF_MAX_COLS,
   parameter int KERNEL_ROWS = DEF_KERNEL_ROWS
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             csr_we,
   input  logic [CFG_W-1:0] csr_wdata,
   sfa_req_if.sink          req_bus,
   sfa_rsp_if.source        rsp_bus
);

   localparam int CHUNKS  = (MAX_COLS + LANES - 1) / LANES;
   localparam int CHUNK_W = (CHUNKS > 1) ? $clog2(CHUNKS) : 1;
   localparam int KDEPTH  = KERNEL_ROWS * CHUNKS;
   localparam int KADDR_W = (KDEPTH > 1) ? $clog2(KDEPTH) : 1;
   localparam int CNT_W   = $clog2(CHUNKS + 1);
   localparam int MC_W    = $clog2(MAX_COLS + 1);
   localparam int CW      = (MC_W > CFG_W) ? MC_W : CFG_W;

   typedef enum logic [3:0] {
      ST_IDLE   = 4'b0001,
      ST_ISSUE  = 4'b0010,
      ST_DRAIN  = 4'b0100,
      ST_RESULT = 4'b1000
   } state_type;

   state_type                 state_ff, state_in;
   logic [CNT_W-1:0]          cnt_ff, cnt_in;
   logic [CHUNK_W-1:0]        chunk_ff, chunk_in;
   op_type                    op_ff;
   logic [7:0]                krow_ff;
   logic [5:0]                col_ff;
   logic [1:0]                trow_ff;
   logic [7:0]                lbyte_ff;
   logic [TILE_ROWS-1:0][7:0] rowval_ff;
   logic [TILE_ROWS-1:0]      rowen_ff;
   logic                      wb_acc_ff, wb_acc_in;
   logic                      wb_rd_ff, wb_rd_in;
   logic [CHUNK_W-1:0]        wb_chunk_ff;
   logic [7:0]                result_ff, result_in;
   logic                      rsp_valid_ff, rsp_valid_in;
   logic [7:0]                rsp_data_ff;
   logic [CFG_W-1:0]          active_ff;
   logic [CHUNKS-1:0]         tvalid_ff [TILE_ROWS];
   logic [CHUNKS-1:0]         tvalid_in [TILE_ROWS];

   logic                      accept;
   logic                      rsp_load;
   op_type                    req_op;
   logic [TILE_ROWS-1:0]      req_mask;
   logic                      krow_ok;
   logic                      col_ok;
   logic [CW-1:0]             cols_eff;
   logic [CNT_W-1:0]          nchunks;
   logic [CNT_W-1:0]          req_cnt;
   logic [CHUNK_W-1:0]        req_chunk;

   issue_type                 issue;
   wb_type                    wb;
   logic [KADDR_W-1:0]        kaddr;
   logic [LANES-1:0]          lane_sel;
   logic [LANES-1:0]          lane_on;
   logic [TILE_ROWS-1:0][7:0] lane_q [LANES];

   // The request side is open only between words; the response register sits apart so that a
   // new word may be taken while the previous answer still waits.
   assign req_bus.ready      = (state_ff == ST_IDLE);
   assign accept             = req_bus.valid && req_bus.ready;
   assign rsp_bus.valid      = rsp_valid_ff;
   assign rsp_bus.read_value = rsp_data_ff;

   // Decode of the incoming word. Out-of-range rows and columns and the unused pattern and
   // opcode give a word with no sweep at all, which then answers zero.
   always_comb begin
      req_op    = op_type'(req_bus.opcode);
      req_mask  = row_mask(req_bus.pattern);
      krow_ok   = int'(req_bus.kernel_row) < KERNEL_ROWS;
      col_ok    = int'(req_bus.column) < MAX_COLS;
      cols_eff  = (CW'(active_ff) > CW'(MAX_COLS)) ? CW'(MAX_COLS) : CW'(active_ff);
      nchunks   = CNT_W'(({1'b0, cols_eff} + (CW + 1)'(LANES - 1)) >> LANE_W);
      req_chunk = CHUNK_W'(req_bus.column >> LANE_W);
      case (req_op)
         OP_LOAD: req_cnt = (krow_ok && col_ok) ? CNT_W'(1) : '0;
         OP_ACC:  req_cnt = (krow_ok && (req_mask != '0)) ? nchunks : '0;
         OP_READ: req_cnt = col_ok ? CNT_W'(1) : '0;
         default: req_cnt = '0;
      endcase
   end

   // Sequencer: one column chunk is issued per cycle to all lanes; the write-back of a chunk
   // runs in the cycle after its issue, and the drain state finishes the last one.
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      chunk_in     = chunk_ff;
      rsp_valid_in = rsp_valid_ff;
      rsp_load     = 1'b0;
      if (rsp_bus.valid && rsp_bus.ready) begin
         rsp_valid_in = 1'b0;
      end
      case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               cnt_in   = req_cnt;
               chunk_in = (req_op == OP_ACC) ? '0 : req_chunk;
               state_in = (req_cnt == '0) ? ST_RESULT : ST_ISSUE;
            end
         end
         ST_ISSUE: begin
            cnt_in   = cnt_ff - CNT_W'(1);
            chunk_in = chunk_ff + CHUNK_W'(1);
            if (cnt_ff == CNT_W'(1)) begin
               state_in = ST_DRAIN;
            end
         end
         ST_DRAIN: begin
            state_in = ST_RESULT;
         end
         ST_RESULT: begin
            if (!rsp_valid_ff || rsp_bus.ready) begin
               rsp_load     = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Commands to the lanes.
   always_comb begin
      issue.rd  = (state_ff == ST_ISSUE) && ((op_ff == OP_ACC) || (op_ff == OP_READ));
      issue.kwe = (state_ff == ST_ISSUE) && (op_ff == OP_LOAD);
      kaddr     = KADDR_W'(int'(krow_ff) * CHUNKS + int'(chunk_ff));
      wb_acc_in = issue.rd && (op_ff == OP_ACC);
      wb_rd_in  = issue.rd && (op_ff == OP_READ);
      for (int r = 0; r < TILE_ROWS; r++) begin
         wb.acc_en[r] = wb_acc_ff && rowen_ff[r];
         wb.valid[r]  = tvalid_ff[r][wb_chunk_ff];
         wb.clr_en[r] = wb_rd_ff && (trow_ff == 2'(r));
      end
      for (int l = 0; l < LANES; l++) begin
         lane_sel[l] = (col_ff[LANE_W-1:0] == LANE_W'(l));
         lane_on[l]  = (int'(wb_chunk_ff) * LANES + l) < int'(cols_eff);
      end
   end

   // A tile word becomes valid once an accumulate has written all of its lanes.
   always_comb begin
      for (int r = 0; r < TILE_ROWS; r++) begin
         tvalid_in[r] = tvalid_ff[r];
         if (wb.acc_en[r]) begin
            tvalid_in[r][wb_chunk_ff] = 1'b1;
         end
      end
   end

   // Merge: the read-and-clear answer is picked from the addressed lane and row.
   always_comb begin
      result_in = result_ff;
      if (accept) begin
         result_in = 8'd0;
      end else if (wb_rd_ff) begin
         result_in = lane_q[col_ff[LANE_W-1:0]][trow_ff];
      end
   end

   for (genvar l = 0; l < LANES; l++) begin : g_lane
      sfa_lane #(
         .MAX_COLS    (MAX_COLS),
         .KERNEL_ROWS (KERNEL_ROWS)
      ) u_lane (
         .clock    (clock),
         .issue    (issue),
         .kaddr    (kaddr),
         .chunk    (chunk_ff),
         .kdata    (lbyte_ff),
         .wb       (wb),
         .wb_chunk (wb_chunk_ff),
         .row_val  (rowval_ff),
         .lane_sel (lane_sel[l]),
         .lane_on  (lane_on[l]),
         .tile_q   (lane_q[l])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         wb_acc_ff    <= 1'b0;
         wb_rd_ff     <= 1'b0;
         rsp_valid_ff <= 1'b0;
         active_ff    <= CFG_W'(DEF_MAX_COLS);
         for (int r = 0; r < TILE_ROWS; r++) begin
            tvalid_ff[r] <= '0;
         end
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         wb_acc_ff    <= wb_acc_in;
         wb_rd_ff     <= wb_rd_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_we) begin
            active_ff <= csr_wdata;
         end
         for (int r = 0; r < TILE_ROWS; r++) begin
            tvalid_ff[r] <= tvalid_in[r];
         end
      end
   end

   // Payload registers carry no reset.
   always_ff @(posedge clock) begin
      chunk_ff    <= chunk_in;
      wb_chunk_ff <= chunk_ff;
      result_ff   <= result_in;
      if (accept) begin
         op_ff     <= req_op;
         krow_ff   <= req_bus.kernel_row;
         col_ff    <= req_bus.column;
         trow_ff   <= req_bus.tile_row;
         lbyte_ff  <= req_bus.load_byte;
         rowen_ff  <= (req_op == OP_ACC) ? req_mask : '0;
         rowval_ff <= spread_values(req_mask, {req_bus.val_fourth, req_bus.val_third,
                                               req_bus.val_second, req_bus.val_first});
      end
      if (rsp_load) begin
         rsp_data_ff <= result_ff;
      end
   end

   a_wb_after_issue: assert property (@(posedge clock) disable iff (reset)
      (wb_acc_ff || wb_rd_ff) |-> $past(state_ff == ST_ISSUE))
      else $error("write-back without a preceding issue cycle");

   a_issue_count: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_ISSUE) |-> (cnt_ff != '0))
      else $error("issue state entered with no chunk left");

   a_rsp_from_result: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_RESULT))
      else $error("response raised outside the result state");

   a_read_then_result: assert property (@(posedge clock) disable iff (reset)
      wb_rd_ff |=> (state_ff == ST_RESULT))
      else $error("read write-back not followed by the result state");

   a_zero_unless_read: assert property (@(posedge clock) disable iff (reset)
      ((state_ff == ST_RESULT) && (op_ff != OP_READ)) |-> (result_ff == 8'd0))
      else $error("nonzero answer for a word that is not a tile read");

endmodule

// ----- dv/tb_sparse_four_row_int8_accumulate.sv -----
// Self-checking testbench for the sparse four-row int8 accumulator: directed words, then
// random load/accumulate/read sequences under several column counts, with random stalls.
// Depends on sfa_pkg, sfa_req_if, sfa_rsp_if and sparse_four_row_int8_accumulate.
`timescale 1ns / 100ps

module tb_sparse_four_row_int8_accumulate;
   import sfa_pkg::*;

   localparam int SETTLE_CYCLES    = 12;
   localparam int HOLD_CYCLES      = 300;
   localparam int GROUPS_PER_PHASE = 6;
   localparam int TIMEOUT_NS       = 10_000_000;

   // Tile rows hit by each pattern, bit r for row r, in pattern order.
   localparam logic [3:0] ROW_SELECT [PATTERN_COUNT] = '{
      4'hF, 4'h7, 4'hB, 4'hD, 4'hE,
      4'h3, 4'h5, 4'h9, 4'h6, 4'hA, 4'hC,
      4'h1, 4'h2, 4'h4, 4'h8
   };

   // Column counts of the random phases: default, small, saturating, one, odd, none, default, odd.
   localparam logic [CFG_W-1:0] PHASE_COLS [8] = '{
      7'd64, 7'd16, 7'd127, 7'd1, 7'd37, 7'd0, 7'd64, 7'd17
   };

   // One request word as the block sees it; vals[0] goes to the first selected row.
   typedef struct packed {
      op_type          op;
      logic [7:0]      kernel_row;
      logic [5:0]      column;
      logic [1:0]      tile_row;
      logic [7:0]      load_byte;
      logic [3:0]      pattern;
      logic [3:0][7:0] vals;
   } acc_cmd_type;

   // Keeps its own copy of the kernel and the tile, works out the read_value of every
   // accepted word and checks the response words against it in order.
   class accum_scoreboard;
      logic [7:0]  kernel_mem [DEF_KERNEL_ROWS][DEF_MAX_COLS];
      logic [7:0]  tile_mem [TILE_ROWS][DEF_MAX_COLS];
      logic [7:0]  expected_bytes [$];
      int unsigned sweep_cols;
      int          errors;

      function new();
         foreach (kernel_mem[r, c]) kernel_mem[r][c] = '0;
         foreach (tile_mem[r, c]) tile_mem[r][c] = '0;
         sweep_cols = DEF_MAX_COLS;
         errors     = 0;
      endfunction

      // Counts above the tile width sweep the whole width.
      function void set_active_cols(input int unsigned value);
         sweep_cols = (value > DEF_MAX_COLS) ? DEF_MAX_COLS : value;
      endfunction

      function int pending();
         return expected_bytes.size();
      endfunction

      function void note_word(input acc_cmd_type cmd);
         logic [7:0] result;
         logic [3:0] rows;
         logic [7:0] weight;
         int         next;
         result = '0;
         case (cmd.op)
            OP_LOAD: kernel_mem[cmd.kernel_row][cmd.column] = cmd.load_byte;
            OP_ACC: begin
               // Pattern 15 selects no row and leaves the tile alone.
               if (cmd.pattern < PATTERN_COUNT) begin
                  rows = ROW_SELECT[cmd.pattern];
                  next = 0;
                  for (int r = 0; r < TILE_ROWS; r++) begin
                     if (rows[r]) begin
                        weight = cmd.vals[next];
                        next++;
                        // Product and sum both wrap to 8 bits.
                        for (int c = 0; c < sweep_cols; c++)
                           tile_mem[r][c] = tile_mem[r][c] +
                                            weight * kernel_mem[cmd.kernel_row][c];
                     end
                  end
               end
            end
            OP_READ: begin
               result = tile_mem[cmd.tile_row][cmd.column];
               tile_mem[cmd.tile_row][cmd.column] = '0;
            end
            default: ;
         endcase
         expected_bytes.push_back(result);
      endfunction

      task report(input string what);
         errors++;
         $display("%0t ns: %s", $time, what);
      endtask

      task check_result(input logic [7:0] got);
         logic [7:0] want;
         if (expected_bytes.size() == 0) begin
            report($sformatf("read_value %0d with no word outstanding", $signed(got)));
         end else begin
            want = expected_bytes.pop_front();
            if (got !== want)
               report($sformatf("read_value %0d, expected %0d", $signed(got), $signed(want)));
         end
      endtask
   endclass

   logic                clock;
   logic                reset;
   logic                csr_we;
   logic [CFG_W-1:0]    csr_wdata;

   sfa_req_if req_bus ();
   sfa_rsp_if rsp_bus ();

   accum_scoreboard ledger = new();

   // Kernel bytes the stimulus has written; an accumulate only ever sweeps written bytes.
   bit         kernel_loaded [DEF_KERNEL_ROWS][DEF_MAX_COLS];
   logic [7:0] filled_rows [$];
   bit         steady;
   bit         hold_req;
   bit         hold_done;

   sparse_four_row_int8_accumulate i_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_wdata (csr_wdata),
      .req_bus   (req_bus),
      .rsp_bus   (rsp_bus)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // Both channels are sampled at the edge, before the block's own updates land.
   always @(posedge clock) begin
      acc_cmd_type seen;
      if (!reset && rsp_bus.valid && rsp_bus.ready) ledger.check_result(rsp_bus.read_value);
      if (!reset && req_bus.valid && req_bus.ready) begin
         seen.op         = op_type'(req_bus.opcode);
         seen.kernel_row = req_bus.kernel_row;
         seen.column     = req_bus.column;
         seen.tile_row   = req_bus.tile_row;
         seen.load_byte  = req_bus.load_byte;
         seen.pattern    = req_bus.pattern;
         seen.vals       = {req_bus.val_fourth, req_bus.val_third,
                            req_bus.val_second, req_bus.val_first};
         ledger.note_word(seen);
      end
   end

   // Mostly short gaps, now and then a long one.
   function automatic int gap_cycles();
      int pick;
      pick = $urandom_range(0, 99);
      if (pick < 55) return 0;
      if (pick < 85) return $urandom_range(1, 2);
      if (pick < 97) return $urandom_range(3, 8);
      return $urandom_range(20, 50);
   endfunction

   function automatic logic [7:0] rand_byte();
      case ($urandom_range(0, 9))
         0:       return 8'h80;
         1:       return 8'h7F;
         2:       return 8'hFF;
         3:       return 8'h01;
         4:       return 8'h00;
         default: return 8'($urandom_range(0, 255));
      endcase
   endfunction

   // A word of the given kind with every other field random, so unused fields toggle too.
   function automatic acc_cmd_type scrambled_word(input op_type op);
      logic [63:0] bits;
      acc_cmd_type cmd;
      bits   = {$urandom(), $urandom()};
      cmd    = acc_cmd_type'(bits[$bits(acc_cmd_type)-1:0]);
      cmd.op = op;
      return cmd;
   endfunction

   function automatic acc_cmd_type load_word(input logic [7:0] row, input logic [5:0] col,
                                             input logic [7:0] value);
      acc_cmd_type cmd;
      cmd            = scrambled_word(OP_LOAD);
      cmd.kernel_row = row;
      cmd.column     = col;
      cmd.load_byte  = value;
      return cmd;
   endfunction

   // vals is written fourth..first, so the rightmost byte is the first selected row's.
   function automatic acc_cmd_type acc_word(input logic [7:0] row, input logic [3:0] pat,
                                            input logic [3:0][7:0] vals);
      acc_cmd_type cmd;
      cmd            = scrambled_word(OP_ACC);
      cmd.kernel_row = row;
      cmd.pattern    = pat;
      cmd.vals       = vals;
      return cmd;
   endfunction

   function automatic acc_cmd_type read_word(input logic [1:0] trow, input logic [5:0] col);
      acc_cmd_type cmd;
      cmd          = scrambled_word(OP_READ);
      cmd.tile_row = trow;
      cmd.column   = col;
      return cmd;
   endfunction

   // Called at a rising edge; returns at the edge where the word is taken.
   task automatic send_word(input acc_cmd_type cmd);
      int gap;
      gap = steady ? 0 : gap_cycles();
      if (gap > 0) begin
         req_bus.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      if (cmd.op == OP_LOAD) kernel_loaded[cmd.kernel_row][cmd.column] = 1'b1;
      req_bus.valid      <= 1'b1;
      req_bus.opcode     <= cmd.op;
      req_bus.kernel_row <= cmd.kernel_row;
      req_bus.column     <= cmd.column;
      req_bus.tile_row   <= cmd.tile_row;
      req_bus.load_byte  <= cmd.load_byte;
      req_bus.pattern    <= cmd.pattern;
      req_bus.val_first  <= cmd.vals[0];
      req_bus.val_second <= cmd.vals[1];
      req_bus.val_third  <= cmd.vals[2];
      req_bus.val_fourth <= cmd.vals[3];
      @(posedge clock);
      while (!req_bus.ready) @(posedge clock);
   endtask

   // Stops offering and waits until every response word is in and the block is quiet.
   // One edge goes by first so that the word taken last is already in the ledger.
   task automatic drain();
      req_bus.valid <= 1'b0;
      @(posedge clock);
      while (ledger.pending() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_active_cols(input logic [CFG_W-1:0] value);
      drain();
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(posedge clock);
      csr_we    <= 1'b0;
      ledger.set_active_cols(value);
   endtask

   // One well-formed sequence: make sure a kernel row is written over the swept columns,
   // accumulate it into the tile a few times, read some tile bytes back, maybe add noise.
   task automatic run_group();
      logic [7:0]  row;
      logic [3:0]  pat;
      logic [5:0]  col;
      acc_cmd_type cmd;
      steady = ($urandom_range(0, 4) == 0);
      if (filled_rows.size() < 2 || $urandom_range(0, 7) == 0) begin
         case ($urandom_range(0, 3))
            0:       row = 8'd0;
            1:       row = 8'd255;
            default: row = 8'($urandom_range(0, 255));
         endcase
         filled_rows.push_back(row);
      end else begin
         row = filled_rows[$urandom_range(0, filled_rows.size() - 1)];
      end
      for (int c = 0; c < ledger.sweep_cols; c++)
         if (!kernel_loaded[row][c]) send_word(load_word(row, 6'(c), rand_byte()));
      repeat ($urandom_range(1, 4)) begin
         pat = ($urandom_range(0, 9) == 0) ? 4'd15 : 4'($urandom_range(0, 14));
         send_word(acc_word(row, pat, {rand_byte(), rand_byte(), rand_byte(), rand_byte()}));
      end
      repeat ($urandom_range(0, 3)) begin
         // Reads lean toward the swept columns, where the tile holds something.
         if (ledger.sweep_cols == 0 || $urandom_range(0, 3) == 0)
            col = 6'($urandom_range(0, 63));
         else
            col = 6'($urandom_range(0, ledger.sweep_cols - 1));
         send_word(read_word(2'($urandom_range(0, 3)), col));
      end
      if ($urandom_range(0, 2) == 0) begin
         // Noise: an unused opcode, a stray kernel write, a stray read, or an empty pattern.
         case ($urandom_range(0, 3))
            0:       cmd = scrambled_word(OP_NONE);
            1:       cmd = scrambled_word(OP_LOAD);
            2:       cmd = scrambled_word(OP_READ);
            default: begin
               cmd         = scrambled_word(OP_ACC);
               cmd.pattern = 4'd15;
            end
         endcase
         send_word(cmd);
      end
   endtask

   // Response side: random runs of ready with random stalls, plus one long hold-off that
   // lets the block back up and stall its request side.
   initial begin : rsp_side
      int stall;
      rsp_bus.ready <= 1'b0;
      @(posedge clock);
      forever begin
         if (hold_req && !hold_done) begin
            hold_done = 1'b1;
            rsp_bus.ready <= 1'b0;
            repeat (HOLD_CYCLES) @(posedge clock);
         end
         rsp_bus.ready <= 1'b1;
         repeat (($urandom_range(0, 9) == 0) ? 80 : $urandom_range(1, 24)) @(posedge clock);
         stall = gap_cycles();
         if (stall > 0) begin
            rsp_bus.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
      end
   end

   initial begin : watchdog
      #(TIMEOUT_NS);
      $display("sparse_four_row_int8_accumulate: mismatch");
      $finish;
   end

   initial begin : stimulus
      acc_cmd_type cmd;
      reset              <= 1'b1;
      csr_we             <= 1'b0;
      csr_wdata          <= '0;
      req_bus.valid      <= 1'b0;
      req_bus.opcode     <= '0;
      req_bus.kernel_row <= '0;
      req_bus.column     <= '0;
      req_bus.tile_row   <= '0;
      req_bus.load_byte  <= '0;
      req_bus.pattern    <= '0;
      req_bus.val_first  <= '0;
      req_bus.val_second <= '0;
      req_bus.val_third  <= '0;
      req_bus.val_fourth <= '0;
      steady    = 1'b0;
      hold_req  = 1'b0;
      hold_done = 1'b0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // Directed part, at the reset column count of 64. The tile reads zero after reset.
      send_word(read_word(2'd3, 6'd63));
      send_word(read_word(2'd0, 6'd0));
      // Unused opcode with every other field at its top.
      cmd    = '1;
      cmd.op = OP_NONE;
      send_word(cmd);
      // Kernel bytes at the corners of the kernel, with the extreme values.
      send_word(load_word(8'd255, 6'd63, 8'h80));
      send_word(load_word(8'd0, 6'd0, 8'h7F));
      send_word(load_word(8'd255, 6'd0, 8'hFF));
      send_word(load_word(8'd0, 6'd63, 8'h01));
      // The empty pattern touches nothing.
      send_word(acc_word(8'd0, 4'd15, {4{8'h80}}));

      // A single column, so only the bytes just written are swept.
      write_active_cols(7'd1);
      send_word(acc_word(8'd255, 4'd0, {8'h01, 8'hFF, 8'h7F, 8'h80}));
      send_word(acc_word(8'd0, 4'd14, {8'h00, 8'h00, 8'h00, 8'h7F}));
      // Three rows; the fourth value is left over and has to be ignored.
      send_word(acc_word(8'd0, 4'd4, {8'h55, 8'h7F, 8'h00, 8'hFF}));
      send_word(acc_word(8'd255, 4'd10, {8'hAA, 8'h33, 8'h80, 8'h01}));
      for (int r = 0; r < TILE_ROWS; r++) send_word(read_word(2'(r), 6'd0));
      // Reading clears the byte.
      send_word(read_word(2'd3, 6'd0));
      send_word(acc_word(8'd0, 4'd11, {4{8'h7F}}));

      // Zero columns: the accumulate sweeps nothing.
      write_active_cols(7'd0);
      send_word(acc_word(8'd255, 4'd0, {8'h7F, 8'h80, 8'h7F, 8'h80}));
      send_word(read_word(2'd0, 6'd0));
      send_word(read_word(2'd1, 6'd0));

      // Random phases, each under its own column count.
      foreach (PHASE_COLS[p]) begin
         write_active_cols(PHASE_COLS[p]);
         if (p == 1) hold_req = 1'b1;
         repeat (GROUPS_PER_PHASE) run_group();
      end

      drain();
      if (ledger.errors == 0) begin
         $display("sparse_four_row_int8_accumulate: match");
      end else begin
         $display("sparse_four_row_int8_accumulate: mismatch");
      end
      $finish;
   end

endmodule
